@@ rtl/mpfb_pkg.sv @@
// ----------------------------------------------------------------------------
// mpfb_pkg
// Shared types and constants of the multi-port I/O FIFO bank.
// ----------------------------------------------------------------------------
package mpfb_pkg;

	// Default configuration
	localparam int DEF_PORT_COUNT = 4;
	localparam int DEF_FIFO_DEPTH = 10;

	// Widest word-store address over the full parameter range (8 ports, depth 256)
	localparam int MEM_ADDR_W = 12;

	// Result queue depth; enough to cover the store read stage at full rate
	localparam int OUT_DEPTH = 4;
	// Command queue depth between front and back
	localparam int CMD_DEPTH = 2;

	localparam int DATA_W = 16;

	typedef enum logic [2:0] {
		CMD_BIND    = 3'd0,
		CMD_DEV_PUT = 3'd1,
		CMD_CPU_IN  = 3'd2,
		CMD_CPU_OUT = 3'd3,
		CMD_DEV_GET = 3'd4
	} command_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_PORT = 3'd1,
		ST_BOUND    = 3'd2,
		ST_FULL     = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	// Request from the CPU/device side
	typedef struct packed {
		logic [2:0]        command;
		logic [2:0]        port_number;
		logic [DATA_W-1:0] write_data;
	} request_t;

	// Result returned for every request
	typedef struct packed {
		logic [2:0]        status;
		logic [DATA_W-1:0] read_data;
	} result_t;

	// Classified operation handed from front to back
	typedef struct packed {
		logic [2:0]            status;
		logic                  wr;
		logic                  rd;
		logic [MEM_ADDR_W-1:0] addr;
		logic [DATA_W-1:0]     data;
	} op_t;

endpackage

@@ rtl/mpfb_queue.sv @@
// ----------------------------------------------------------------------------
// mpfb_queue
// Small register-based FIFO used between front, back and the result port.
// ----------------------------------------------------------------------------
module mpfb_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/mpfb_front.sv @@
// ----------------------------------------------------------------------------
// mpfb_front
// Checks each request against the port bindings and fill counts, updates
// the ring pointers and emits a classified store operation.
// ----------------------------------------------------------------------------
module mpfb_front #(
	parameter int PORT_COUNT = mpfb_pkg::DEF_PORT_COUNT,
	parameter int FIFO_DEPTH = mpfb_pkg::DEF_FIFO_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  mpfb_pkg::request_t request,
	output mpfb_pkg::op_t      op
);

	localparam int PORT_W     = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
	localparam int FIFO_COUNT = 2 * PORT_COUNT;
	localparam int FIDX_W     = PORT_W + 1;
	localparam int SLOT_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);
	localparam int MA_W       = mpfb_pkg::MEM_ADDR_W;

	logic              bound_q [PORT_COUNT];
	logic [SLOT_W-1:0] head_q  [FIFO_COUNT];
	logic [SLOT_W-1:0] tail_q  [FIFO_COUNT];
	logic [FILL_W-1:0] fill_q  [FIFO_COUNT];

	logic              port_ok;
	logic [PORT_W-1:0] port_idx;
	logic              dir;
	logic [FIDX_W-1:0] fidx;
	logic [FIDX_W-1:0] fidx_in;
	logic [FIDX_W-1:0] fidx_out;
	logic              port_bound;
	logic [FILL_W-1:0] fill_cur;
	logic [SLOT_W-1:0] slot;
	logic              do_bind;
	logic              do_push;
	logic              do_pop;
	mpfb_pkg::status_t status;

	// Address decode
	assign port_ok  = ({1'b0, request.port_number} < 4'(PORT_COUNT));
	assign port_idx = request.port_number[PORT_W-1:0];
	assign dir      = (request.command == mpfb_pkg::CMD_CPU_OUT) ||
	                  (request.command == mpfb_pkg::CMD_DEV_GET);
	assign fidx     = {port_idx, dir};
	assign fidx_in  = {port_idx, 1'b0};
	assign fidx_out = {port_idx, 1'b1};
	assign port_bound = port_ok && bound_q[port_idx];
	assign fill_cur = fill_q[fidx];

	// Command classification
	always_comb begin
		status  = mpfb_pkg::ST_BAD_PORT;
		do_bind = 1'b0;
		do_push = 1'b0;
		do_pop  = 1'b0;
		if (port_ok) begin
			unique case (mpfb_pkg::command_t'(request.command)) inside
				mpfb_pkg::CMD_BIND: begin
					if (port_bound) begin
						status = mpfb_pkg::ST_BOUND;
					end else begin
						status  = mpfb_pkg::ST_OK;
						do_bind = 1'b1;
					end
				end
				mpfb_pkg::CMD_DEV_PUT, mpfb_pkg::CMD_CPU_OUT: begin
					if (!port_bound) begin
						status = mpfb_pkg::ST_BAD_PORT;
					end else if (fill_cur == FILL_W'(FIFO_DEPTH)) begin
						status = mpfb_pkg::ST_FULL;
					end else begin
						status  = mpfb_pkg::ST_OK;
						do_push = 1'b1;
					end
				end
				mpfb_pkg::CMD_CPU_IN, mpfb_pkg::CMD_DEV_GET: begin
					if (!port_bound) begin
						status = mpfb_pkg::ST_BAD_PORT;
					end else if (fill_cur == '0) begin
						status = mpfb_pkg::ST_EMPTY;
					end else begin
						status = mpfb_pkg::ST_OK;
						do_pop = 1'b1;
					end
				end
				default: status = mpfb_pkg::ST_BAD_PORT;
			endcase
		end
	end

	// Store address: fifo * depth + slot
	assign slot = do_push ? tail_q[fidx] : head_q[fidx];

	always_comb begin
		op.status = status;
		op.wr     = do_push;
		op.rd     = do_pop;
		op.addr   = MA_W'(MA_W'(fidx) * MA_W'(FIFO_DEPTH)) + MA_W'(slot);
		op.data   = request.write_data;
	end

	// Binding flags and ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PORT_COUNT; p++) begin
				bound_q[p] <= 1'b0;
			end
			for (int f = 0; f < FIFO_COUNT; f++) begin
				head_q[f] <= '0;
				tail_q[f] <= '0;
				fill_q[f] <= '0;
			end
		end else if (accept) begin
			if (do_bind) begin
				bound_q[port_idx] <= 1'b1;
				head_q[fidx_in]   <= '0;
				tail_q[fidx_in]   <= '0;
				fill_q[fidx_in]   <= '0;
				head_q[fidx_out]  <= '0;
				tail_q[fidx_out]  <= '0;
				fill_q[fidx_out]  <= '0;
			end
			if (do_push) begin
				tail_q[fidx] <= (tail_q[fidx] == SLOT_W'(FIFO_DEPTH - 1)) ?
				                '0 : tail_q[fidx] + 1'b1;
				fill_q[fidx] <= fill_cur + 1'b1;
			end
			if (do_pop) begin
				head_q[fidx] <= (head_q[fidx] == SLOT_W'(FIFO_DEPTH - 1)) ?
				                '0 : head_q[fidx] + 1'b1;
				fill_q[fidx] <= fill_cur - 1'b1;
			end
		end
	end

endmodule

@@ rtl/mpfb_back.sv @@
// ----------------------------------------------------------------------------
// mpfb_back
// Carries out classified operations on the shared word store and builds
// results; issues only when the result queue has room for them.
// ----------------------------------------------------------------------------
module mpfb_back #(
	parameter int PORT_COUNT = mpfb_pkg::DEF_PORT_COUNT,
	parameter int FIFO_DEPTH = mpfb_pkg::DEF_FIFO_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	input  mpfb_pkg::op_t     op,
	output logic              op_take,
	output logic              res_push,
	output mpfb_pkg::result_t res,
	input  logic              res_taken
);

	localparam int MEM_DEPTH = 2 * PORT_COUNT * FIFO_DEPTH;
	localparam int MA_W      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int OCC_W     = $clog2(mpfb_pkg::OUT_DEPTH + 1);

	logic [mpfb_pkg::DATA_W-1:0] mem_q [MEM_DEPTH];
	logic [mpfb_pkg::DATA_W-1:0] rdata_s1;
	logic [2:0]                  status_s1;
	logic                        rd_s1;
	logic                        valid_s1;
	logic [OCC_W-1:0]            occ_q;
	logic [MA_W-1:0]             addr;

	// Results in flight plus queued must fit the result queue
	assign op_take = op_valid && (occ_q < OCC_W'(mpfb_pkg::OUT_DEPTH));
	assign addr    = op.addr[MA_W-1:0];

	// Word store
	always_ff @(posedge clk) begin
		if (op_take && op.wr) begin
			mem_q[addr] <= op.data;
		end
		if (op_take && op.rd) begin
			rdata_s1 <= mem_q[addr];
		end
	end

	// Result stage
	always_ff @(posedge clk) begin
		if (op_take) begin
			status_s1 <= op.status;
			rd_s1     <= op.rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			occ_q    <= '0;
		end else begin
			valid_s1 <= op_take;
			if (op_take && !res_taken) begin
				occ_q <= occ_q + 1'b1;
			end else if (res_taken && !op_take) begin
				occ_q <= occ_q - 1'b1;
			end
		end
	end

	assign res_push      = valid_s1;
	assign res.status    = status_s1;
	assign res.read_data = rd_s1 ? rdata_s1 : '0;

endmodule

@@ rtl/multi_port_io_fifo_bank.sv @@
// ----------------------------------------------------------------------------
// multi_port_io_fifo_bank
// I/O port bank: per-port bind flag and input/output word rings.
// ----------------------------------------------------------------------------
// Request path: command queue, back result stage, result queue; then empty falls.
// Throughput: one request per cycle (single-port store) unless results are not taken.
// Full rises when the two-entry command queue fills; it drains while results are taken.
// Reset (arst_n low, asynchronous): all ports unbound, all rings empty, queues empty.
// Word store contents are not cleared; they are only read after being written.
// ----------------------------------------------------------------------------
module multi_port_io_fifo_bank #(
	parameter int PORT_COUNT = mpfb_pkg::DEF_PORT_COUNT,
	parameter int FIFO_DEPTH = mpfb_pkg::DEF_FIFO_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  mpfb_pkg::request_t request,
	output logic               empty,
	input  logic               pop,
	output mpfb_pkg::result_t  result
);

	localparam int OP_W  = $bits(mpfb_pkg::op_t);
	localparam int RES_W = $bits(mpfb_pkg::result_t);

	logic              accept;
	mpfb_pkg::op_t     op_front;
	mpfb_pkg::op_t     op_back;
	logic              cmd_empty;
	logic              op_take;
	logic              res_push;
	mpfb_pkg::result_t res_back;
	logic              res_full;
	logic              res_taken;
	logic [OP_W-1:0]   op_bits;
	logic [RES_W-1:0]  res_bits;

	assign accept    = push && !full;
	assign res_taken = pop && !empty;

	// Front: classify and update ring state
	mpfb_front #(
		.PORT_COUNT(PORT_COUNT),
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.request(request),
		.op     (op_front)
	);

	// Operation queue between front and back
	mpfb_queue #(
		.WIDTH(OP_W),
		.DEPTH(mpfb_pkg::CMD_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (accept),
		.wdata (op_front),
		.full  (full),
		.pop   (op_take),
		.rdata (op_bits),
		.empty (cmd_empty)
	);

	assign op_back = mpfb_pkg::op_t'(op_bits);

	// Back: word store access and result build
	mpfb_back #(
		.PORT_COUNT(PORT_COUNT),
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (!cmd_empty),
		.op       (op_back),
		.op_take  (op_take),
		.res_push (res_push),
		.res      (res_back),
		.res_taken(res_taken)
	);

	// Result queue; back never pushes into a full queue
	mpfb_queue #(
		.WIDTH(RES_W),
		.DEPTH(mpfb_pkg::OUT_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push && !res_full),
		.wdata (res_back),
		.full  (res_full),
		.pop   (res_taken),
		.rdata (res_bits),
		.empty (empty)
	);

	assign result = mpfb_pkg::result_t'(res_bits);

endmodule
